// ----- sv/bos_pkg.sv -----
// bos_pkg: shared constants, types and the outline function of the
// bitmap outline shadow block; no dependencies
`timescale 1ns / 1ps

package bos_pkg;

  localparam int WORD_BITS = 32;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  // edge pixels of a neighbouring word: row above, current row, row below
  typedef struct packed {
    logic up;
    logic cur;
    logic down;
  } nbr_t;

  typedef struct packed {
    word_t black_out;
    logic  line_end;
  } result_t;

  // horizontal 3-wide dilation of one row with its edge neighbours
  function automatic word_t spread_row(word_t w, logic left, logic right);
    word_t r;
    r = w | (w << 1) | (w >> 1);
    r[WORD_BITS-1] = r[WORD_BITS-1] | left;
    r[0] = r[0] | right;
    return r;
  endfunction

  // black OR (3x3 dilation of white AND NOT current white)
  function automatic word_t outline_word(word_t up, word_t cur, word_t down,
                                         word_t black, nbr_t left, nbr_t right);
    word_t dil;
    dil = spread_row(up, left.up, right.up)
        | spread_row(cur, left.cur, right.cur)
        | spread_row(down, left.down, right.down);
    return black | (dil & ~cur);
  endfunction

endpackage

// ----- sv/bos_if.sv -----
// bos_in_if / bos_out_if: valid/ready channels of the outline block
// depends on bos_pkg for the word width
`timescale 1ns / 1ps

interface bos_in_if;
  logic               valid;
  logic               ready;
  bos_pkg::word_t     white_above;
  bos_pkg::word_t     white_current;
  bos_pkg::word_t     white_below;
  bos_pkg::word_t     black_current;
  logic               above_present;
  logic               first_word;
  logic               last_word;

  modport source (output valid, white_above, white_current, white_below,
                  black_current, above_present, first_word, last_word,
                  input ready);
  modport sink   (input valid, white_above, white_current, white_below,
                  black_current, above_present, first_word, last_word,
                  output ready);
endinterface

interface bos_out_if;
  logic               valid;
  logic               ready;
  bos_pkg::word_t     black_out;
  logic               line_end;

  modport source (output valid, black_out, line_end, input ready);
  modport sink   (input valid, black_out, line_end, output ready);
endinterface

// ----- sv/bitmap_outline_shadow.sv -----
// bitmap_outline_shadow: draws a one-pixel dark outline around white overlay
// pixels; depends on bos_pkg and the channel interfaces in bos_if.sv
`timescale 1ns / 1ps

// Takes one overlay word per clock (white above/current/below plus black) and
// returns black OR the 3x3 dilation of white outside current white, leftmost
// pixel in the MSB. A word's result needs its right-hand neighbour, so output
// lags input by one word; the last word of a line releases two results, and
// a first_word arriving while a word is held closes the open line first.
// Results pass through a 4-entry queue, one result per clock while the
// sink is ready; pix_in.ready is high while two or more entries are free,
// so with the sink taking every cycle the block accepts one item per clock.
module bitmap_outline_shadow (
  input  logic      clk,
  input  logic      rst,
  bos_in_if.sink    pix_in,
  bos_out_if.source pix_out
);

  // word waiting for its right-hand neighbour
  bos_pkg::word_t held_up;
  bos_pkg::word_t held_cur;
  bos_pkg::word_t held_down;
  bos_pkg::word_t held_black;
  bos_pkg::nbr_t  left_bits;
  logic           held_valid;

  // result queue
  bos_pkg::result_t                  queue [bos_pkg::QUEUE_DEPTH];
  logic [bos_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [bos_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [bos_pkg::QUEUE_CW-1:0]      count;
  logic [bos_pkg::QUEUE_CW-1:0]      count_next;

  logic             take;
  logic             pop;
  logic             flush;
  logic             cont;
  logic             push0;
  logic             push1;
  bos_pkg::word_t   up_in;
  bos_pkg::nbr_t    new_top;
  bos_pkg::nbr_t    right_held;
  bos_pkg::nbr_t    left_new;
  bos_pkg::result_t res_held;
  bos_pkg::result_t res_new;
  bos_pkg::result_t slot0;

  assign pix_in.ready = count <= bos_pkg::QUEUE_CW'(bos_pkg::QUEUE_DEPTH - 2);
  assign take         = pix_in.valid && pix_in.ready;
  assign pop          = pix_out.valid && pix_out.ready;

  assign flush = held_valid && pix_in.first_word;
  assign cont  = held_valid && !pix_in.first_word;
  assign up_in = pix_in.above_present ? pix_in.white_above : '0;

  always_comb begin
    new_top.up   = up_in[bos_pkg::WORD_BITS-1];
    new_top.cur  = pix_in.white_current[bos_pkg::WORD_BITS-1];
    new_top.down = pix_in.white_below[bos_pkg::WORD_BITS-1];
    right_held   = flush ? '0 : new_top;
    left_new     = '0;
    if (cont) begin
      left_new.up   = held_up[0];
      left_new.cur  = held_cur[0];
      left_new.down = held_down[0];
    end
    res_held.black_out = bos_pkg::outline_word(held_up, held_cur, held_down,
                                               held_black, left_bits, right_held);
    res_held.line_end  = flush;
    res_new.black_out  = bos_pkg::outline_word(up_in, pix_in.white_current,
                                               pix_in.white_below,
                                               pix_in.black_current,
                                               left_new, '0);
    res_new.line_end   = 1'b1;
    slot0 = held_valid ? res_held : res_new;
  end

  assign push0 = take && (held_valid || pix_in.last_word);
  assign push1 = take && held_valid && pix_in.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      left_bits  <= '0;
    end else if (take) begin
      held_valid <= !pix_in.last_word;
      left_bits  <= pix_in.last_word ? '0 : left_new;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_up    <= up_in;
      held_cur   <= pix_in.white_current;
      held_down  <= pix_in.white_below;
      held_black <= pix_in.black_current;
    end
  end

  // queue storage: up to two writes per transfer, results in order
  always_ff @(posedge clk) begin
    if (push0) begin
      queue[wr_ptr] <= slot0;
    end
    if (push1) begin
      queue[wr_ptr + 1'b1] <= res_new;
    end
  end

  always_comb begin
    count_next = count + bos_pkg::QUEUE_CW'(push0) + bos_pkg::QUEUE_CW'(push1)
               - bos_pkg::QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bos_pkg::QUEUE_AW'(push0) + bos_pkg::QUEUE_AW'(push1);
      rd_ptr <= rd_ptr + bos_pkg::QUEUE_AW'(pop);
      count  <= count_next;
    end
  end

  assign pix_out.valid     = count != '0;
  assign pix_out.black_out = queue[rd_ptr].black_out;
  assign pix_out.line_end  = queue[rd_ptr].line_end;

endmodule

// ----- bench/bos_outline_checker.sv -----
// bos_outline_checker: watches both channels of the outline block, predicts
// each result word and compares it; depends on bos_pkg and bos_if.sv
`timescale 1ns / 1ps

module bos_outline_checker (
  input  logic clk,
  input  logic rst,
  bos_in_if    pix_in,
  bos_out_if   pix_out,
  output int   mismatches,
  output int   outline_pending
);

  localparam int WB = bos_pkg::WORD_BITS;

  // the word waiting for its right-hand neighbour
  bos_pkg::word_t hold_up;
  bos_pkg::word_t hold_cur;
  bos_pkg::word_t hold_down;
  bos_pkg::word_t hold_black;
  logic [2:0]     left_edge;  // up, cur, down
  logic           hold_full;

  bos_pkg::result_t outline_due[$];

  task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // horizontal 3-wide dilation with the edge pixels of the neighbour words
  function automatic bos_pkg::word_t grow_row(bos_pkg::word_t w, logic lft, logic rgt);
    logic [WB+1:0] ext;
    ext = {lft, w, rgt};
    return w | ext[WB+1:2] | ext[WB-1:0];
  endfunction

  function automatic bos_pkg::result_t held_outline(logic [2:0] rgt, logic fin);
    bos_pkg::result_t r;
    bos_pkg::word_t   dil;
    dil = grow_row(hold_up, left_edge[2], rgt[2])
        | grow_row(hold_cur, left_edge[1], rgt[1])
        | grow_row(hold_down, left_edge[0], rgt[0]);
    r.black_out = hold_black | (dil & ~hold_cur);
    r.line_end  = fin;
    return r;
  endfunction

  task automatic predict_outline(bos_pkg::word_t above, bos_pkg::word_t cur,
                                 bos_pkg::word_t below, bos_pkg::word_t black,
                                 logic present, logic first, logic last);
    bos_pkg::word_t up;
    up = present ? above : '0;
    // a new line closes one left open
    if (hold_full && first) begin
      outline_due.push_back(held_outline(3'b000, 1'b1));
      hold_full = 1'b0;
      left_edge = '0;
    end
    if (hold_full) begin
      outline_due.push_back(held_outline({up[WB-1], cur[WB-1], below[WB-1]}, 1'b0));
      left_edge = {hold_up[0], hold_cur[0], hold_down[0]};
    end else begin
      left_edge = '0;
    end
    hold_up    = up;
    hold_cur   = cur;
    hold_down  = below;
    hold_black = black;
    hold_full  = 1'b1;
    if (last) begin
      outline_due.push_back(held_outline(3'b000, 1'b1));
      hold_full = 1'b0;
      left_edge = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    bos_pkg::result_t due;
    if (rst) begin
      hold_up    = '0;
      hold_cur   = '0;
      hold_down  = '0;
      hold_black = '0;
      left_edge  = '0;
      hold_full  = 1'b0;
      outline_due.delete();
    end else begin
      if (pix_in.valid && pix_in.ready)
        predict_outline(pix_in.white_above, pix_in.white_current, pix_in.white_below,
                        pix_in.black_current, pix_in.above_present, pix_in.first_word,
                        pix_in.last_word);
      if (pix_out.valid && pix_out.ready) begin
        if (outline_due.size() == 0) begin
          report_mismatch("result with nothing expected", pix_out.black_out, '0);
        end else begin
          due = outline_due.pop_front();
          if (pix_out.black_out !== due.black_out)
            report_mismatch("black_out", pix_out.black_out, due.black_out);
          if (pix_out.line_end !== due.line_end)
            report_mismatch("line_end", WB'(pix_out.line_end), WB'(due.line_end));
        end
      end
    end
    outline_pending <= outline_due.size();
  end

endmodule

// ----- bench/bitmap_outline_shadow_test.sv -----
// bitmap_outline_shadow_test: drives overlay lines into the outline block
// and gives the verdict; depends on bos_pkg, bos_if.sv and bos_outline_checker
`timescale 1ns / 1ps

module bitmap_outline_shadow_test;

  localparam int WB          = bos_pkg::WORD_BITS;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 185;

  logic clk;
  logic rst;
  logic hold_req;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   words_sent;
  int   mismatches;
  int   outline_pending;

  bos_in_if  pix_in();
  bos_out_if pix_out();

  bitmap_outline_shadow dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  bos_outline_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .pix_in          (pix_in),
    .pix_out         (pix_out),
    .mismatches      (mismatches),
    .outline_pending (outline_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin : sink_side
    int   held;
    logic hold_done;
    hold_done = 1'b0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        pix_out.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bos_pkg::word_t pick_word();
    bos_pkg::word_t w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = $urandom & $urandom & $urandom;
      3: w = $urandom | $urandom;
      4: w = bos_pkg::word_t'(1) << $urandom_range(WB - 1);
      5: begin
        // only the edge pixels, which cross into the neighbour words
        w = '0;
        w[WB-1] = 1'($urandom_range(1));
        w[0] = 1'($urandom_range(1));
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_word(bos_pkg::word_t above, bos_pkg::word_t cur,
                           bos_pkg::word_t below, bos_pkg::word_t black,
                           logic present, logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid         <= 1'b1;
    pix_in.white_above   <= above;
    pix_in.white_current <= cur;
    pix_in.white_below   <= below;
    pix_in.black_current <= black;
    pix_in.above_present <= present;
    pix_in.first_word    <= first;
    pix_in.last_word     <= last;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    words_sent++;
  endtask

  // mostly well-formed lines, some with a flag missing, a few with random flags
  task automatic send_line();
    int   kind;
    int   n;
    int   k;
    logic f;
    logic l;
    kind = $urandom_range(99);
    n = ($urandom_range(19) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
    for (k = 0; k < n; k++) begin
      f = (k == 0);
      l = (k == n - 1);
      if (kind >= 92) begin
        f = 1'($urandom_range(1));
        l = 1'($urandom_range(1));
      end else if (kind >= 84) begin
        l = 1'b0;
      end else if (kind >= 76) begin
        f = 1'b0;
      end
      send_word(pick_word(), pick_word(), pick_word(),
                ($urandom_range(2) == 0) ? pick_word() : bos_pkg::word_t'(0),
                $urandom_range(9) != 0, f, l);
    end
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (outline_pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    rst                  <= 1'b1;
    hold_req              = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    words_sent            = 0;
    pix_in.valid         <= 1'b0;
    pix_in.white_above   <= '0;
    pix_in.white_current <= '0;
    pix_in.white_below   <= '0;
    pix_in.black_current <= '0;
    pix_in.above_present <= 1'b0;
    pix_in.first_word    <= 1'b0;
    pix_in.last_word     <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one-word lines: empty, all white, edge pixels with row above absent, all black
    send_word('0, '0, '0, '0, 1'b1, 1'b1, 1'b1);
    send_word('1, '1, '1, '0, 1'b1, 1'b1, 1'b1);
    send_word(bos_pkg::word_t'(1), {1'b1, {(WB-1){1'b0}}}, {1'b1, {(WB-1){1'b0}}}, '0,
              1'b0, 1'b1, 1'b1);
    send_word('0, '0, '0, '1, 1'b0, 1'b1, 1'b1);
    // two-word line with white touching the word boundary from both sides
    send_word(bos_pkg::word_t'(1), bos_pkg::word_t'(1), '0, '0, 1'b1, 1'b1, 1'b0);
    send_word('0, {1'b1, {(WB-1){1'b0}}}, {1'b1, {(WB-1){1'b0}}}, '0, 1'b1, 1'b0, 1'b1);
    // three words, row above all white but flagged absent in the middle
    send_word('1, 32'h0001_8000, '0, '0, 1'b1, 1'b1, 1'b0);
    send_word('1, 32'h8000_0001, '0, 32'h0F0F_0000, 1'b0, 1'b0, 1'b0);
    send_word('1, '0, 32'h8000_0001, '0, 1'b1, 1'b0, 1'b1);
    // line left open, closed by the next first word
    send_word('0, bos_pkg::word_t'(1), '1, '0, 1'b1, 1'b1, 1'b0);
    send_word('0, 32'hFFFF_0000, '0, '0, 1'b1, 1'b0, 1'b0);
    send_word(bos_pkg::word_t'(1), 32'h8000_0000, '0, '0, 1'b1, 1'b1, 1'b0);
    send_word('0, 32'h5555_5555, '0, '0, 1'b1, 1'b0, 1'b1);
    // line started without a first word
    send_word(32'hAAAA_AAAA, bos_pkg::word_t'(1), '0, '0, 1'b1, 1'b0, 1'b0);
    send_word('0, {1'b1, {(WB-1){1'b0}}}, 32'h0000_FFFF, '0, 1'b1, 1'b0, 1'b1);
    // words with no flags at all, then a one-word line right after
    send_word('1, '0, '0, '0, 1'b1, 1'b0, 1'b0);
    send_word('0, '0, '1, '0, 1'b1, 1'b0, 1'b0);
    send_word('0, '1, '0, '0, 1'b0, 1'b1, 1'b1);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 0) begin
        repeat (8) send_line();
        // result side holds off while lines keep coming, so the input stalls
        hold_req = 1'b1;
      end
      while (words_sent < 20 + (ph + 1) * PHASE_WORDS) send_line();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outline_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
